@@ src/bhc_pkg.sv @@
// Shared types and constants of the byte histogram counter.
package bhc_pkg;

    localparam int SYMBOL_W    = 8;
    localparam int BIN_COUNT_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_OUT
    } bhc_state_t;

    typedef struct packed {
        logic accept;
        logic cnt_write;
        logic scan_hit;
        logic scan_next;
        logic scan_done;
        logic out_load;
    } bhc_cmd_t;

    typedef struct packed {
        logic is_report;
        logic in_range;
        logic at_end;
        logic bin_nonzero;
        logic out_free;
    } bhc_status_t;

endpackage

@@ src/bhc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module bhc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/bhc_ctrl.sv @@
// Controller state machine that sequences count and report transactions.
module bhc_ctrl
    import bhc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  bhc_status_t status,
    output bhc_cmd_t    cmd
);

    bhc_state_t state_reg;
    bhc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (status.is_report) begin
                        state_next = ST_SCAN_RD;
                    end else if (status.in_range) begin
                        state_next = ST_CNT_RD;
                    end
                end
            end
            ST_CNT_RD: begin
                state_next = ST_CNT_WR;
            end
            ST_CNT_WR: begin
                cmd.cnt_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SCAN_RD: begin
                if (status.at_end) begin
                    cmd.scan_done = 1'b1;
                    state_next    = ST_OUT;
                end else begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                if (status.bin_nonzero) begin
                    cmd.scan_hit = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/bhc_datapath.sv @@
// Datapath with the bin memory, scan position, result and output registers.
module bhc_datapath
    import bhc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16,
    parameter int NUM_BINS    = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_action,
    input  logic [SYMBOL_W-1:0]    s_symbol,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SYMBOL_W-1:0]    m_bin_symbol,
    output logic [BIN_COUNT_W-1:0] m_bin_count,
    output logic                   m_done_res,
    input  bhc_cmd_t               cmd,
    output bhc_status_t            status
);

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam int POS_W  = $clog2(NUM_BINS + 1);
    localparam int EXT_W  = (COUNT_WIDTH > BIN_COUNT_W) ? COUNT_WIDTH : BIN_COUNT_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [POS_W-1:0]       addr_reg;
    logic [POS_W-1:0]       addr_next;
    logic [POS_W-1:0]       scan_pos_reg;
    logic [POS_W-1:0]       scan_pos_next;
    logic [NUM_BINS-1:0]    valid_reg;
    logic [SYMBOL_W-1:0]    res_symbol_reg;
    logic [BIN_COUNT_W-1:0] res_count_reg;
    logic                   res_done_reg;
    logic                   m_valid_reg;
    logic [SYMBOL_W-1:0]    m_bin_symbol_reg;
    logic [BIN_COUNT_W-1:0] m_bin_count_reg;
    logic                   m_done_res_reg;

    logic [ADDR_W-1:0]      addr_idx;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] bin_value;
    logic [COUNT_WIDTH-1:0] bin_inc;
    logic [EXT_W-1:0]       bin_ext;
    logic [BIN_COUNT_W-1:0] bin_sat;
    logic                   ram_we;
    logic [COUNT_WIDTH-1:0] ram_wdata;

    assign addr_idx  = addr_reg[ADDR_W-1:0];
    assign bin_value = valid_reg[addr_idx] ? ram_rdata : '0;
    assign bin_inc   = (bin_value == COUNT_MAX) ? bin_value : bin_value + 1'b1;
    assign bin_ext   = EXT_W'(bin_value);
    assign bin_sat   = (bin_ext > EXT_W'({BIN_COUNT_W{1'b1}})) ?
                       {BIN_COUNT_W{1'b1}} : bin_ext[BIN_COUNT_W-1:0];
    assign ram_we    = cmd.cnt_write | cmd.scan_hit;
    assign ram_wdata = cmd.cnt_write ? bin_inc : '0;

    bhc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr_idx),
        .wdata (ram_wdata),
        .raddr (addr_idx),
        .rdata (ram_rdata)
    );

    always_comb begin
        addr_next = addr_reg;
        if (cmd.accept) begin
            addr_next = s_action ? scan_pos_reg : POS_W'(s_symbol);
        end else if (cmd.scan_next) begin
            addr_next = addr_reg + 1'b1;
        end
        scan_pos_next = scan_pos_reg;
        if (cmd.scan_done) begin
            scan_pos_next = '0;
        end else if (cmd.scan_hit) begin
            scan_pos_next = addr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_pos_reg <= '0;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            scan_pos_reg <= scan_pos_next;
            if (ram_we) begin
                valid_reg[addr_idx] <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        if (cmd.scan_hit) begin
            res_symbol_reg <= SYMBOL_W'(addr_idx);
            res_count_reg  <= bin_sat;
            res_done_reg   <= 1'b0;
        end else if (cmd.scan_done) begin
            res_symbol_reg <= '0;
            res_count_reg  <= '0;
            res_done_reg   <= 1'b1;
        end
        if (cmd.out_load) begin
            m_bin_symbol_reg <= res_symbol_reg;
            m_bin_count_reg  <= res_count_reg;
            m_done_res_reg   <= res_done_reg;
        end
    end

    assign status.is_report   = s_action;
    assign status.in_range    = ({1'b0, s_symbol} < (SYMBOL_W + 1)'(NUM_BINS));
    assign status.at_end      = (addr_reg >= POS_W'(NUM_BINS));
    assign status.bin_nonzero = (bin_value != '0);
    assign status.out_free    = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_bin_symbol = m_bin_symbol_reg;
    assign m_bin_count  = m_bin_count_reg;
    assign m_done_res   = m_done_res_reg;

endmodule

@@ src/byte_histogram_counter.sv @@
// Top level of the byte histogram counter.
// A count transaction is accepted, its bin is read from the bin memory and the updated
// count is written back; a count whose symbol has no bin ends in the cycle it is accepted.
// A report transaction is accepted, then reads and checks each bin in turn, from the scan
// position up to the first bin that is not zero, passes through one more read state when
// it runs past the last bin, and moves the result into the output register; that last step
// waits as long as the previous result is still held there. Each bin is read and checked
// in separate states because the bin memory has a single read port, whose read data is
// registered.
// The block takes a new transaction while a report result still waits on the output.
// Bins read as zero right after reset; no clearing pass is needed.
module byte_histogram_counter
    import bhc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16,
    parameter int NUM_BINS    = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_action,
    input  logic [SYMBOL_W-1:0]    s_symbol,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SYMBOL_W-1:0]    m_bin_symbol,
    output logic [BIN_COUNT_W-1:0] m_bin_count,
    output logic                   m_done_res
);

    bhc_cmd_t    cmd;
    bhc_status_t status;

    bhc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bhc_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .NUM_BINS    (NUM_BINS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_action     (s_action),
        .s_symbol     (s_symbol),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bin_symbol (m_bin_symbol),
        .m_bin_count  (m_bin_count),
        .m_done_res   (m_done_res),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench of the byte histogram counter with a driver, a monitor and a predictor.
module testbench
    import bhc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_WIDTH = 16;
    localparam int NUM_BINS    = 256;
    localparam longint unsigned COUNT_TOP = (64'd1 << COUNT_WIDTH) - 1;
    localparam int RANDOM_ITEMS = 1000;
    localparam int QUIET_TAIL   = 150;
    localparam int SAME_BIN_RUN = 40;
    localparam int DRAIN_CYCLES = 600;
    localparam int BACKLOG_HOLD = 300;

    typedef enum logic {
        ACT_COUNT  = 1'b0,
        ACT_REPORT = 1'b1
    } hist_action_t;

    typedef struct {
        hist_action_t        action;
        logic [SYMBOL_W-1:0] symbol;
        bit                  quiet;
    } hist_req_t;

    typedef struct {
        logic [SYMBOL_W-1:0]    symbol;
        logic [BIN_COUNT_W-1:0] count;
        logic                   done;
    } bin_report_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_action;
    logic [SYMBOL_W-1:0]    s_symbol;
    logic                   m_valid;
    logic                   m_ready;
    logic [SYMBOL_W-1:0]    m_bin_symbol;
    logic [BIN_COUNT_W-1:0] m_bin_count;
    logic                   m_done_res;

    hist_req_t       byte_stream_q[$];
    bin_report_t     expected_reports[$];
    longint unsigned tally_bins[NUM_BINS];
    int              scan_next;
    int              queued_items;
    int              accepted_items;
    int              reports_seen;
    int              in_gap;
    int              out_stall;
    int              backlog_hold;
    bit              backlog_done;
    bit              in_taken;
    bit              quiet_phase;
    bit              check_failed;

    byte_histogram_counter #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .NUM_BINS   (NUM_BINS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_symbol    (s_symbol),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bin_symbol(m_bin_symbol),
        .m_bin_count (m_bin_count),
        .m_done_res  (m_done_res)
    );

    always #5 aclk = ~aclk;

    task automatic push_item(input hist_action_t act, input logic [SYMBOL_W-1:0] sym,
                             input bit quiet);
        hist_req_t req;
        req.action = act;
        req.symbol = sym;
        req.quiet  = quiet;
        byte_stream_q.push_back(req);
        queued_items++;
    endtask

    task automatic apply_to_histogram(input hist_action_t act,
                                      input logic [SYMBOL_W-1:0] sym);
        bin_report_t res;
        int hit;
        hit = -1;
        if (act == ACT_COUNT) begin
            if (int'(sym) < NUM_BINS && tally_bins[sym] < COUNT_TOP) begin
                tally_bins[sym]++;
            end
        end else begin
            for (int pos = scan_next; pos < NUM_BINS && hit < 0; pos++) begin
                if (tally_bins[pos] != 0) begin
                    hit = pos;
                end
            end
            if (hit >= 0) begin
                res.symbol = SYMBOL_W'(hit);
                res.count  = (tally_bins[hit] > 64'hFFFF) ? 16'hFFFF
                                                          : BIN_COUNT_W'(tally_bins[hit]);
                res.done   = 1'b0;
                tally_bins[hit] = 0;
                scan_next = (hit + 1) & 9'h1FF;
            end else begin
                res.symbol = '0;
                res.count  = '0;
                res.done   = 1'b1;
                scan_next  = 0;
            end
            expected_reports.push_back(res);
        end
    endtask

    // Input side: a new item is loaded only after the previous one has been taken.
    always @(negedge aclk) begin
        hist_req_t nxt;
        if (aresetn && (!s_valid || in_taken)) begin
            in_taken = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                s_valid <= 1'b0;
            end else if (byte_stream_q.size() > 0) begin
                nxt = byte_stream_q.pop_front();
                s_valid     <= 1'b1;
                s_action    <= nxt.action;
                s_symbol    <= nxt.symbol;
                quiet_phase = nxt.quiet;
                if (!nxt.quiet && $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(1, 4);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            in_taken = 1'b1;
            accepted_items++;
            apply_to_histogram(hist_action_t'(s_action), s_symbol);
        end
    end

    // Output side: short random stalls, plus one long hold-off while items are still queued
    // so that the block backs up into its input.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (backlog_hold > 0) begin
            backlog_hold--;
            m_ready <= 1'b0;
        end else if (!backlog_done && !quiet_phase && reports_seen >= 8
                     && byte_stream_q.size() > 40) begin
            backlog_done = 1'b1;
            backlog_hold = BACKLOG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (out_stall > 0) begin
            out_stall--;
            m_ready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            out_stall = $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        bin_report_t want;
        if (aresetn && m_valid && m_ready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
                $error("unexpected transaction: bin_symbol %0d bin_count %0d done_res %0d",
                       m_bin_symbol, m_bin_count, m_done_res);
                check_failed = 1'b1;
            end else begin
                want = expected_reports.pop_front();
                if (m_bin_symbol !== want.symbol) begin
                    $error("bin_symbol: expected %0d, got %0d", want.symbol, m_bin_symbol);
                    check_failed = 1'b1;
                end
                if (m_bin_count !== want.count) begin
                    $error("bin_count: expected %0d, got %0d", want.count, m_bin_count);
                    check_failed = 1'b1;
                end
                if (m_done_res !== want.done) begin
                    $error("done_res: expected %0d, got %0d", want.done, m_done_res);
                    check_failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        int rand_start;
        int run_len;
        int base;
        int span;
        int reps;
        bit quiet;
        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_action = 1'b0;
        s_symbol = '0;
        m_ready  = 1'b0;
        for (int i = 0; i < NUM_BINS; i++) begin
            tally_bins[i] = 0;
        end
        scan_next = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty scan, both symbol extremes, the zero byte, counts behind the scan.
        push_item(ACT_REPORT, 8'h00, 1'b0);
        push_item(ACT_COUNT, 8'h00, 1'b0);
        push_item(ACT_COUNT, 8'hFF, 1'b0);
        push_item(ACT_COUNT, 8'h00, 1'b0);
        push_item(ACT_COUNT, 8'h80, 1'b0);
        push_item(ACT_COUNT, 8'h55, 1'b0);
        push_item(ACT_COUNT, 8'hAA, 1'b0);
        push_item(ACT_COUNT, 8'h01, 1'b0);
        push_item(ACT_REPORT, 8'hFF, 1'b0);
        push_item(ACT_REPORT, 8'h00, 1'b0);
        push_item(ACT_REPORT, 8'h5A, 1'b0);
        push_item(ACT_COUNT, 8'h20, 1'b0);
        push_item(ACT_COUNT, 8'hFE, 1'b0);
        push_item(ACT_COUNT, 8'h55, 1'b0);
        for (int i = 0; i < 7; i++) begin
            push_item(ACT_REPORT, 8'(i * 37), 1'b0);
        end

        // A long run of counts into a single bin, then the end of the pass and the bin's report.
        for (int i = 0; i < SAME_BIN_RUN; i++) begin
            push_item(ACT_COUNT, 8'h3C, 1'b1);
        end
        push_item(ACT_REPORT, 8'h3C, 1'b1);
        push_item(ACT_REPORT, 8'hC3, 1'b1);

        // Random part: mostly bursts of counts followed by a report pass, some plain noise.
        rand_start = queued_items;
        while (queued_items < rand_start + RANDOM_ITEMS) begin
            quiet = (queued_items >= rand_start + RANDOM_ITEMS - QUIET_TAIL);
            if ($urandom_range(0, 9) < 7) begin
                run_len = $urandom_range(1, 24);
                base    = $urandom_range(0, 255);
                span    = $urandom_range(0, 1) ? 255 : $urandom_range(0, 15);
                for (int k = 0; k < run_len; k++) begin
                    push_item(ACT_COUNT, 8'(base + $urandom_range(0, span)), quiet);
                end
                reps = $urandom_range(1, run_len + 2);
                for (int k = 0; k < reps; k++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        push_item(ACT_COUNT, 8'($urandom), quiet);
                    end
                    push_item(ACT_REPORT, 8'($urandom), quiet);
                end
            end else begin
                run_len = $urandom_range(1, 8);
                for (int k = 0; k < run_len; k++) begin
                    push_item(hist_action_t'($urandom_range(0, 1)), 8'($urandom), quiet);
                end
            end
        end

        while (accepted_items != queued_items) @(posedge aclk);
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (!check_failed) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
